FILE: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/lsws_pkg.sv
package lsws_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 7;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_UNDER = 2'd1;
   localparam logic [1:0] STATUS_OVER  = 2'd2;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_PEEK   = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SRCH,
      ST_SRCH_END
   } state_type;

endpackage

FILE: sv/lifo_stack_with_search_core.sv
// LIFO stack of signed 32-bit words with a membership search, held in a 64-entry memory
// plus a depth register. A transaction is accepted when start is high and busy is low.
// Each result has rsp_valid high for exactly one cycle and cannot be stalled, so the
// receiver must take it in that cycle. A push keeps busy low and its result shows in the
// cycle after it is accepted. Pop and peek go through the READ state since the memory read
// is registered. A search reads one stored entry per cycle through the same read port in
// the SRCH state, compares it against the key and answers from SRCH_END, or from idle on
// an empty stack. Pop or peek on an empty stack returns underflow; a push on a full stack
// returns overflow and drops the word. Every result carries the resulting entry count.
`include "assert_macros.svh"

module lifo_stack_with_search_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_type,
   input  logic signed [31:0]       req_value,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_data,
   output logic                     rsp_found,
   output logic [6:0]               rsp_count
);

   localparam int ADDR_W  = lsws_pkg::ADDR_W;
   localparam int DEPTH_W = lsws_pkg::DEPTH_W;
   localparam int DATA_W  = lsws_pkg::DATA_W;
   localparam int COUNT_W = lsws_pkg::COUNT_W;

   lsws_pkg::state_type    state_ff, state_in;
   lsws_pkg::req_kind_type op_ff, op_in, req_kind;

   logic [DATA_W-1:0]  value_ff, value_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic               cmp_vld_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic [DATA_W-1:0]  mem [lsws_pkg::STACK_DEPTH];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               accept;
   logic               empty;
   logic               full;
   logic               match;
   logic               last_idx;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  top_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DEPTH_W-1:0] depth_dec;
   logic [DEPTH_W-1:0] depth_inc;

   assign busy      = (state_ff != lsws_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign req_kind  = lsws_pkg::req_kind_type'(req_type);
   assign empty     = (depth_ff == '0);
   assign full      = (depth_ff == lsws_pkg::DEPTH_MAX);
   assign depth_dec = depth_ff - DEPTH_W'(1);
   assign depth_inc = depth_ff + DEPTH_W'(1);
   assign top_addr  = depth_dec[ADDR_W-1:0];
   assign wr_addr   = depth_ff[ADDR_W-1:0];
   assign last_idx  = (idx_ff == top_addr);
   assign match     = cmp_vld_ff && (rd_data_ff == value_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsws_pkg::ST_IDLE: begin
            if (accept && !empty) begin
               if (req_kind == lsws_pkg::REQ_POP || req_kind == lsws_pkg::REQ_PEEK) begin
                  state_in = lsws_pkg::ST_READ;
               end else if (req_kind == lsws_pkg::REQ_SEARCH) begin
                  state_in = lsws_pkg::ST_SRCH;
               end
            end
         end
         lsws_pkg::ST_READ: begin
            state_in = lsws_pkg::ST_IDLE;
         end
         lsws_pkg::ST_SRCH: begin
            if (last_idx) begin
               state_in = lsws_pkg::ST_SRCH_END;
            end
         end
         lsws_pkg::ST_SRCH_END: begin
            state_in = lsws_pkg::ST_IDLE;
         end
         default: begin
            state_in = lsws_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control and result
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      depth_in      = depth_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff || match;
      wr_en         = 1'b0;
      rd_addr       = top_addr;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      case (state_ff)
         lsws_pkg::ST_IDLE: begin
            if (accept) begin
               op_in        = req_kind;
               value_in     = req_value;
               idx_in       = '0;
               hit_in       = 1'b0;
               rsp_data_in  = '0;
               rsp_found_in = 1'b0;
               case (req_kind)
                  lsws_pkg::REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = lsws_pkg::STATUS_OVER;
                     end else begin
                        rsp_status_in = lsws_pkg::STATUS_OK;
                        wr_en         = 1'b1;
                        depth_in      = depth_inc;
                     end
                  end
                  lsws_pkg::REQ_POP, lsws_pkg::REQ_PEEK: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lsws_pkg::STATUS_UNDER;
                     end
                  end
                  lsws_pkg::REQ_SEARCH: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lsws_pkg::STATUS_OK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         lsws_pkg::ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = lsws_pkg::STATUS_OK;
            rsp_data_in   = rd_data_ff;
            rsp_found_in  = 1'b0;
            if (op_ff == lsws_pkg::REQ_POP) begin
               depth_in = depth_dec;
            end
         end
         lsws_pkg::ST_SRCH: begin
            rd_addr = idx_ff;
            idx_in  = idx_ff + ADDR_W'(1);
         end
         lsws_pkg::ST_SRCH_END: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = lsws_pkg::STATUS_OK;
            rsp_data_in   = '0;
            rsp_found_in  = hit_ff || match;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      rsp_count_in = COUNT_W'(depth_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsws_pkg::ST_IDLE;
         depth_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cmp_vld_ff   <= (state_ff == lsws_pkg::ST_SRCH);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // stack memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

   `ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= lsws_pkg::DEPTH_MAX)
   `ASSERT_IMP(a_srch_idx, clock, reset, state_ff == lsws_pkg::ST_SRCH,
      !empty && (DEPTH_W'(idx_ff) < depth_ff))
   `ASSERT_NXT(a_pop_read, clock, reset, accept && req_kind == lsws_pkg::REQ_POP && !empty,
      state_ff == lsws_pkg::ST_READ && busy)
   `ASSERT_NXT(a_push_grow, clock, reset, accept && req_kind == lsws_pkg::REQ_PUSH && !full,
      rsp_valid && depth_ff == $past(depth_inc))
   `ASSERT_IMP(a_under_empty, clock, reset, rsp_valid && rsp_status == lsws_pkg::STATUS_UNDER,
      empty && rsp_data == '0)

endmodule

FILE: bench/tb_lifo_stack_with_search_core.sv
`timescale 1ns / 100ps

module tb_lifo_stack_with_search_core;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 363;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] data;
      logic        found;
      logic [6:0]  count;
   } stack_result_type;

   class stack_scoreboard;
      logic [31:0]      words [lsws_pkg::STACK_DEPTH];
      int unsigned      level;
      int               errors;
      stack_result_type awaited_results [$];

      function new();
         level = 0;
         errors = 0;
      endfunction

      // predict the response of one accepted transaction
      function void note_request(lsws_pkg::req_kind_type kind, logic [31:0] value);
         stack_result_type outcome;
         outcome.status = lsws_pkg::STATUS_OK;
         outcome.data = '0;
         outcome.found = 1'b0;
         case (kind)
            lsws_pkg::REQ_PUSH: begin
               if (level >= lsws_pkg::STACK_DEPTH) begin
                  outcome.status = lsws_pkg::STATUS_OVER;
               end else begin
                  words[level] = value;
                  level++;
               end
            end
            lsws_pkg::REQ_POP, lsws_pkg::REQ_PEEK: begin
               if (level == 0) begin
                  outcome.status = lsws_pkg::STATUS_UNDER;
               end else begin
                  outcome.data = words[level - 1];
                  if (kind == lsws_pkg::REQ_POP) begin
                     level--;
                  end
               end
            end
            default: begin
               for (int i = 0; i < level; i++) begin
                  if (words[i] == value) begin
                     outcome.found = 1'b1;
                  end
               end
            end
         endcase
         outcome.count = 7'(level);
         awaited_results.push_back(outcome);
      endfunction

      function void compare_field(string name, logic [31:0] expected_v, logic [31:0] actual_v);
         if (actual_v !== expected_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected_v,
                     actual_v);
            errors++;
         end
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] data, logic found,
                                 logic [6:0] count);
         stack_result_type oldest;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %h data %h",
                     $time, status, data);
            errors++;
         end else begin
            oldest = awaited_results.pop_front();
            compare_field("status", 32'(oldest.status), 32'(status));
            compare_field("data", oldest.data, data);
            compare_field("found", 32'(oldest.found), 32'(found));
            compare_field("count", 32'(oldest.count), 32'(count));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic [1:0]         req_type;
   logic signed [31:0] req_value;
   logic               busy;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic               rsp_found;
   logic [6:0]         rsp_count;

   stack_scoreboard sb;
   int              idle_pct;
   int              cycles;
   logic [31:0]     recent_pushes [$];

   lifo_stack_with_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .req_value  (req_value),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // note accepted transactions before checking so a same-cycle response still lines up
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(lsws_pkg::req_kind_type'(req_type), req_value);
         end
         if (rsp_valid) begin
            sb.check_result(rsp_status, rsp_data, rsp_found, rsp_count);
         end
      end
   end

   task automatic send_request(lsws_pkg::req_kind_type kind, logic [31:0] value);
      int gaps;
      gaps = 0;
      @(negedge clock);
      while (idle_pct != 0 && gaps < 12 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         gaps++;
         @(negedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_value <= value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (kind == lsws_pkg::REQ_PUSH) begin
         recent_pushes.push_back(value);
         if (recent_pushes.size() > 16) begin
            void'(recent_pushes.pop_front());
         end
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4, 5: return 32'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_search_value();
      logic [31:0] stored;
      if (recent_pushes.size() == 0 || $urandom_range(1) == 0) begin
         return pick_value();
      end
      stored = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
      // near miss that differs in a single bit
      if ($urandom_range(3) == 0) begin
         stored[$urandom_range(31)] ^= 1'b1;
      end
      return stored;
   endfunction

   task automatic send_random(int mode);
      int roll;
      roll = $urandom_range(99);
      case (mode)
         0: begin
            if (roll < 85) send_request(lsws_pkg::REQ_PUSH, pick_value());
            else if (roll < 90) send_request(lsws_pkg::REQ_POP, $urandom);
            else if (roll < 95) send_request(lsws_pkg::REQ_PEEK, $urandom);
            else send_request(lsws_pkg::REQ_SEARCH, pick_search_value());
         end
         1: begin
            if (roll < 75) send_request(lsws_pkg::REQ_POP, $urandom);
            else if (roll < 85) send_request(lsws_pkg::REQ_PEEK, $urandom);
            else if (roll < 95) send_request(lsws_pkg::REQ_SEARCH, pick_search_value());
            else send_request(lsws_pkg::REQ_PUSH, pick_value());
         end
         default: begin
            if (roll < 25) send_request(lsws_pkg::REQ_PUSH, pick_value());
            else if (roll < 50) send_request(lsws_pkg::REQ_POP, $urandom);
            else if (roll < 75) send_request(lsws_pkg::REQ_PEEK, $urandom);
            else send_request(lsws_pkg::REQ_SEARCH, pick_search_value());
         end
      endcase
   endtask

   initial begin
      int phase_pct [4];
      int issued;
      int burst_len;
      int mode;
      phase_pct = '{0, 46, 0, 24};
      sb = new();
      cycles = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = lsws_pkg::REQ_PUSH;
      req_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty stack, extremes and searches that hit and miss
      send_request(lsws_pkg::REQ_PEEK, 32'h1234_5678);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_SEARCH, 32'h0);
      send_request(lsws_pkg::REQ_PUSH, 32'h7fff_ffff);
      send_request(lsws_pkg::REQ_PUSH, 32'h8000_0000);
      send_request(lsws_pkg::REQ_PUSH, 32'h0000_0000);
      send_request(lsws_pkg::REQ_PUSH, 32'hffff_ffff);
      send_request(lsws_pkg::REQ_SEARCH, 32'h8000_0000);
      send_request(lsws_pkg::REQ_SEARCH, 32'h8000_0001);
      send_request(lsws_pkg::REQ_SEARCH, 32'h7fff_fffe);
      send_request(lsws_pkg::REQ_SEARCH, 32'h0000_0000);
      send_request(lsws_pkg::REQ_PEEK, 32'hffff_ffff);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_PEEK, 32'h0);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_POP, 32'h0);
      send_request(lsws_pkg::REQ_SEARCH, 32'hffff_ffff);

      // each burst picks filling, draining or mixed traffic at random
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            burst_len = $urandom_range(16, 96);
            mode = $urandom_range(2);
            for (int j = 0; j < burst_len && issued < PHASE_ITEMS; j++) begin
               send_random(mode);
               issued++;
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
